[design/ehbd_pkg.sv]
// ehbd_pkg: shared widths, reset values, register map and control types
// for the echo hiding bit detector; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package ehbd_pkg;

  // field widths
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned SEG_W    = 16;
  localparam int unsigned LAG_W    = 13;
  localparam int unsigned THR_W    = 31;
  localparam int unsigned PROD_W   = 2 * SAMPLE_W;
  localparam int unsigned SUM_W    = 48;

  // stream and bus widths
  localparam int unsigned S_TDATA_W = 16;
  localparam int unsigned M_TDATA_W = 8;
  localparam int unsigned PADDR_W   = 4;
  localparam int unsigned PDATA_W   = 32;

  // default sizing of the top level
  localparam int unsigned MAX_SEGMENT_DEF = 32768;
  localparam int unsigned MAX_LAG_DEF     = 8192;

  // register reset values
  localparam logic [SEG_W-1:0] SEG_LEN_RST   = SEG_W'(17640);
  localparam logic [LAG_W-1:0] LAG_SHORT_RST = LAG_W'(2205);
  localparam logic [LAG_W-1:0] LAG_LONG_RST  = LAG_W'(4410);
  localparam logic [THR_W-1:0] THRESHOLD_RST = THR_W'(5368709);

  // register map, word index of paddr
  typedef enum logic [1:0] {
    REG_SEG_LEN   = 2'd0,
    REG_LAG_SHORT = 2'd1,
    REG_LAG_LONG  = 2'd2,
    REG_THRESHOLD = 2'd3
  } reg_idx_e;

  // serial multiply operations at segment end
  typedef enum logic [1:0] {
    MUL_S0_N1  = 2'd0,
    MUL_S1_N0  = 2'd1,
    MUL_THR_N0 = 2'd2,
    MUL_T_N1   = 2'd3
  } mul_op_e;

  typedef struct packed {
    logic [SEG_W-1:0] seg_len;
    logic [LAG_W-1:0] lag_short;
    logic [LAG_W-1:0] lag_long;
    logic [THR_W-1:0] threshold;
  } cfg_t;

  typedef struct packed {
    logic    accept;
    logic    load_rd;
    logic    acc;
    logic    mul_load;
    mul_op_e op;
    logic    mul_step;
    logic    decide;
  } cmd_t;

  typedef struct packed {
    logic seg_end;
    logic mul_done;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

[design/ehbd_ctrl.sv]
// ehbd_ctrl: one-hot sequencer for sample accumulation and the
// end-of-segment multiply and decide steps; depends on ehbd_pkg
`timescale 1ns / 1ps
`default_nettype none

module ehbd_ctrl
  import ehbd_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_ready_o,
  input  wire status_t sts_i,
  output cmd_t         cmd_o
);

  typedef enum logic [11:0] {
    ST_IDLE   = 12'b0000_0000_0001,
    ST_LOAD   = 12'b0000_0000_0010,
    ST_ACC    = 12'b0000_0000_0100,
    ST_L0     = 12'b0000_0000_1000,
    ST_M0     = 12'b0000_0001_0000,
    ST_L1     = 12'b0000_0010_0000,
    ST_M1     = 12'b0000_0100_0000,
    ST_L2     = 12'b0000_1000_0000,
    ST_M2     = 12'b0001_0000_0000,
    ST_L3     = 12'b0010_0000_0000,
    ST_M3     = 12'b0100_0000_0000,
    ST_DECIDE = 12'b1000_0000_0000
  } state_e;

  state_e state_q, state_d;

  // next state and command decode
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    state_d    = state_q;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) state_d = ST_LOAD;
      end
      ST_LOAD: begin
        cmd_o.load_rd = 1'b1;
        state_d       = ST_ACC;
      end
      ST_ACC: begin
        cmd_o.acc = 1'b1;
        if (sts_i.seg_end) begin
          state_d = ST_L0;
        end else begin
          in_ready_o = 1'b1;
          state_d    = in_valid_i ? ST_LOAD : ST_IDLE;
        end
      end
      ST_L0: begin
        cmd_o.mul_load = 1'b1;
        cmd_o.op       = MUL_S0_N1;
        state_d        = ST_M0;
      end
      ST_M0: begin
        cmd_o.mul_step = 1'b1;
        if (sts_i.mul_done) state_d = ST_L1;
      end
      ST_L1: begin
        cmd_o.mul_load = 1'b1;
        cmd_o.op       = MUL_S1_N0;
        state_d        = ST_M1;
      end
      ST_M1: begin
        cmd_o.mul_step = 1'b1;
        if (sts_i.mul_done) state_d = ST_L2;
      end
      ST_L2: begin
        cmd_o.mul_load = 1'b1;
        cmd_o.op       = MUL_THR_N0;
        state_d        = ST_M2;
      end
      ST_M2: begin
        cmd_o.mul_step = 1'b1;
        if (sts_i.mul_done) state_d = ST_L3;
      end
      ST_L3: begin
        cmd_o.mul_load = 1'b1;
        cmd_o.op       = MUL_T_N1;
        state_d        = ST_M3;
      end
      ST_M3: begin
        cmd_o.mul_step = 1'b1;
        if (sts_i.mul_done) state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (sts_i.out_free) begin
          cmd_o.decide = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    cmd_o.accept = in_ready_o & in_valid_i;
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

[design/ehbd_dp.sv]
// ehbd_dp: sample ring, lag correlation sums, serial shift-add multiplier
// and bit decision with output register; depends on ehbd_pkg
`timescale 1ns / 1ps
`default_nettype none

module ehbd_dp
  import ehbd_pkg::*;
#(
  parameter int unsigned MAX_SEGMENT = MAX_SEGMENT_DEF,
  parameter int unsigned MAX_LAG     = MAX_LAG_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire cfg_t                cfg_i,
  input  wire cmd_t                cmd_i,
  output status_t                  sts_o,
  input  wire logic [SAMPLE_W-1:0] sample_i,
  input  wire logic                restart_i,
  output logic                     data_bit_o,
  output logic                     undecided_o,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i
);

  localparam int unsigned NW   = $clog2(MAX_SEGMENT + 1);
  localparam int unsigned LW   = $clog2(MAX_LAG);
  localparam int unsigned CW   = (NW > SEG_W) ? NW : SEG_W;
  localparam int unsigned LCW  = (NW > LAG_W) ? NW : LAG_W;
  localparam int unsigned MLW  = $clog2(MAX_LAG + 1);
  localparam int unsigned LMW  = (MLW > LAG_W) ? MLW : LAG_W;
  localparam int unsigned ADW  = ((LW > LAG_W) ? LW : LAG_W) + 1;
  localparam int unsigned AW1  = SUM_W + NW + 1;
  localparam int unsigned AW2  = THR_W + 2 * NW + 1;
  localparam int unsigned AW   = (AW1 > AW2) ? AW1 : AW2;

  localparam logic [CW-1:0]  MIN_LEN_C = CW'(2);
  localparam logic [CW-1:0]  MAX_SEG_C = CW'(MAX_SEGMENT);
  localparam logic [LMW-1:0] MAX_LAG_C = LMW'(MAX_LAG);
  localparam logic [LW-1:0]  WPTR_TOP  = LW'(MAX_LAG - 1);

  // lag is nonzero, below the segment length and below the ring depth
  function automatic logic lag_ok(input logic [LAG_W-1:0] lag, input logic [NW-1:0] len);
    lag_ok = (lag != '0) && (LCW'(lag) < LCW'(len)) && (LMW'(lag) < MAX_LAG_C);
  endfunction

  // ring address of the sample lag positions back, wrapped at the depth
  function automatic logic [LW-1:0] ring_addr(input logic [LW-1:0] wptr,
                                              input logic [LAG_W-1:0] lag);
    logic [ADW-1:0] d;
    d = ADW'(wptr) - ADW'(lag);
    if (d[ADW-1]) d = d + ADW'(MAX_LAG);
    ring_addr = d[LW-1:0];
  endfunction

  // effective segment length
  logic [CW-1:0] seg_ext, len_c;
  logic [NW-1:0] len;

  always_comb begin
    seg_ext = CW'(cfg_i.seg_len);
    if (seg_ext < MIN_LEN_C) begin
      len_c = MIN_LEN_C;
    end else if (seg_ext > MAX_SEG_C) begin
      len_c = MAX_SEG_C;
    end else begin
      len_c = seg_ext;
    end
    len = NW'(len_c);
  end

  // lag usability and correlation denominators
  logic          use_s, use_l;
  logic [NW-1:0] n0, n1;

  assign use_s = lag_ok(cfg_i.lag_short, len);
  assign use_l = lag_ok(cfg_i.lag_long, len);
  assign n0    = use_s ? (len - NW'(cfg_i.lag_short)) : NW'(1);
  assign n1    = use_l ? (len - NW'(cfg_i.lag_long)) : NW'(1);

  // segment control registers
  logic [NW-1:0]             pos_q, pos_d;
  logic [LW-1:0]             wptr_q, wptr_d;
  logic signed [SUM_W-1:0]   short_sum_q, short_sum_d;
  logic signed [SUM_W-1:0]   long_sum_q, long_sum_d;
  logic                      prev_q, prev_d;
  logic                      seg_end;

  assign seg_end = ((NW + 1)'(pos_q) + (NW + 1)'(1)) >= (NW + 1)'(len);

  // accepted sample
  logic signed [SAMPLE_W-1:0] samp_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) samp_q <= sample_i;
  end

  // sample ring, one write and two registered reads per sample
  logic signed [SAMPLE_W-1:0] ring_q [MAX_LAG];
  logic signed [SAMPLE_W-1:0] rd_s_q, rd_l_q;
  logic                       en_s_q, en_l_q;
  logic [LW-1:0]              addr_s, addr_l;

  assign addr_s = ring_addr(wptr_q, cfg_i.lag_short);
  assign addr_l = ring_addr(wptr_q, cfg_i.lag_long);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_rd) begin
      ring_q[wptr_q] <= samp_q;
      rd_s_q         <= ring_q[addr_s];
      rd_l_q         <= ring_q[addr_l];
      en_s_q         <= use_s && (LCW'(pos_q) >= LCW'(cfg_i.lag_short));
      en_l_q         <= use_l && (LCW'(pos_q) >= LCW'(cfg_i.lag_long));
    end
  end

  // lag products
  logic signed [PROD_W-1:0] prod_s, prod_l;

  assign prod_s = samp_q * rd_s_q;
  assign prod_l = samp_q * rd_l_q;

  // serial multiplier and decision registers
  logic signed [AW-1:0] mcand_q, acc_q;
  logic [NW-1:0]        mplier_q;
  logic                 sub_q;
  logic [AW-1:0]        mag_q;
  logic                 diff_pos_q;
  logic signed [AW-1:0] s0_ext, s1_ext, thr_ext;
  logic                 und_c, bit_c;

  assign s0_ext  = use_s ? AW'(short_sum_q) : '0;
  assign s1_ext  = use_l ? AW'(long_sum_q) : '0;
  assign thr_ext = $signed({{(AW - THR_W){1'b0}}, cfg_i.threshold});
  assign und_c   = mag_q < $unsigned(acc_q);
  assign bit_c   = und_c ? prev_q : ~diff_pos_q;

  // next values of the segment state
  always_comb begin
    pos_d       = pos_q;
    wptr_d      = wptr_q;
    short_sum_d = short_sum_q;
    long_sum_d  = long_sum_q;
    prev_d      = prev_q;
    if (cmd_i.acc) begin
      if (en_s_q) short_sum_d = short_sum_q + SUM_W'(prod_s);
      if (en_l_q) long_sum_d = long_sum_q + SUM_W'(prod_l);
      if (seg_end) begin
        pos_d  = '0;
        wptr_d = '0;
      end else begin
        pos_d  = pos_q + NW'(1);
        wptr_d = (wptr_q == WPTR_TOP) ? '0 : wptr_q + LW'(1);
      end
    end
    if (cmd_i.decide) begin
      short_sum_d = '0;
      long_sum_d  = '0;
      if (!und_c) prev_d = bit_c;
    end
    // restart realigns the segment and forgets the last bit
    if (cmd_i.accept && restart_i) begin
      pos_d       = '0;
      wptr_d      = '0;
      short_sum_d = '0;
      long_sum_d  = '0;
      prev_d      = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      wptr_q      <= '0;
      short_sum_q <= '0;
      long_sum_q  <= '0;
      prev_q      <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      wptr_q      <= wptr_d;
      short_sum_q <= short_sum_d;
      long_sum_q  <= long_sum_d;
      prev_q      <= prev_d;
    end
  end

  // shift-add multiplier, one multiplier bit per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mcand_q    <= '0;
      acc_q      <= '0;
      mplier_q   <= '0;
      sub_q      <= 1'b0;
      mag_q      <= '0;
      diff_pos_q <= 1'b0;
    end else if (cmd_i.mul_load) begin
      case (cmd_i.op)
        MUL_S0_N1: begin
          mcand_q  <= s0_ext;
          mplier_q <= n1;
          acc_q    <= '0;
          sub_q    <= 1'b0;
        end
        MUL_S1_N0: begin
          mcand_q  <= s1_ext;
          mplier_q <= n0;
          sub_q    <= 1'b1;
        end
        MUL_THR_N0: begin
          // acc holds the cross-multiplied difference here
          mag_q      <= acc_q[AW-1] ? $unsigned(-acc_q) : $unsigned(acc_q);
          diff_pos_q <= !acc_q[AW-1] && (acc_q != '0);
          mcand_q    <= thr_ext;
          mplier_q   <= n0;
          acc_q      <= '0;
          sub_q      <= 1'b0;
        end
        default: begin
          mcand_q  <= acc_q;
          mplier_q <= n1;
          acc_q    <= '0;
          sub_q    <= 1'b0;
        end
      endcase
    end else if (cmd_i.mul_step) begin
      if (mplier_q[0]) acc_q <= sub_q ? (acc_q - mcand_q) : (acc_q + mcand_q);
      mcand_q  <= mcand_q <<< 1;
      mplier_q <= mplier_q >> 1;
    end
  end

  // output register
  logic data_bit_q, und_q, out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.decide) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.decide) begin
      data_bit_q <= bit_c;
      und_q      <= und_c;
    end
  end

  assign data_bit_o  = data_bit_q;
  assign undecided_o = und_q;
  assign out_valid_o = out_valid_q;

  assign sts_o.seg_end  = seg_end;
  assign sts_o.mul_done = (mplier_q == '0);
  assign sts_o.out_free = !out_valid_q || out_ready_i;

endmodule

`default_nettype wire

[design/echo_hiding_bit_detector.sv]
// echo_hiding_bit_detector: top level with registers; uses ehbd_pkg, ehbd_ctrl, ehbd_dp
// a sample word passes a ring read state, then an accumulate state; the next word is
// taken in the accumulate cycle unless the segment ends; a segment's last word yields
// its result word after four one-bit-a-cycle shift-add multiplies and a decide step,
// plus any wait for the output register; async active-low reset clears all but the
// ring, the sample and read registers and the result bits
`timescale 1ns / 1ps
`default_nettype none

module echo_hiding_bit_detector
  import ehbd_pkg::*;
#(
  parameter int unsigned MAX_SEGMENT = MAX_SEGMENT_DEF,
  parameter int unsigned MAX_LAG     = MAX_LAG_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // input stream
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  input  wire logic [S_TDATA_W-1:0] s_axis_tdata,  // [15:0] sample
  input  wire logic [0:0]           s_axis_tuser,  // [0] restart
  // result stream
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  output logic [M_TDATA_W-1:0]      m_axis_tdata,  // [0] data_bit, [7:1] zero
  output logic [0:0]                m_axis_tuser,  // [0] undecided
  // register port
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [PADDR_W-1:0]   paddr,
  input  wire logic [PDATA_W-1:0]   pwdata,
  output logic [PDATA_W-1:0]        prdata,
  output logic                      pready
);

  cfg_t     cfg_q;
  cmd_t     cmd;
  status_t  sts;
  reg_idx_e reg_idx;
  logic     reg_wr;
  logic     data_bit, undecided;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[PADDR_W-1:2]);
  assign reg_wr  = psel & penable & pwrite;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.seg_len   <= SEG_LEN_RST;
      cfg_q.lag_short <= LAG_SHORT_RST;
      cfg_q.lag_long  <= LAG_LONG_RST;
      cfg_q.threshold <= THRESHOLD_RST;
    end else if (reg_wr) begin
      unique case (reg_idx)
        REG_SEG_LEN:   cfg_q.seg_len   <= pwdata[SEG_W-1:0];
        REG_LAG_SHORT: cfg_q.lag_short <= pwdata[LAG_W-1:0];
        REG_LAG_LONG:  cfg_q.lag_long  <= pwdata[LAG_W-1:0];
        REG_THRESHOLD: cfg_q.threshold <= pwdata[THR_W-1:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (reg_idx)
      REG_SEG_LEN:   prdata = PDATA_W'(cfg_q.seg_len);
      REG_LAG_SHORT: prdata = PDATA_W'(cfg_q.lag_short);
      REG_LAG_LONG:  prdata = PDATA_W'(cfg_q.lag_long);
      REG_THRESHOLD: prdata = PDATA_W'(cfg_q.threshold);
      default:       prdata = '0;
    endcase
  end

  ehbd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ehbd_dp #(
    .MAX_SEGMENT (MAX_SEGMENT),
    .MAX_LAG     (MAX_LAG)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .sample_i    (s_axis_tdata[SAMPLE_W-1:0]),
    .restart_i   (s_axis_tuser[0]),
    .data_bit_o  (data_bit),
    .undecided_o (undecided),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready)
  );

  assign m_axis_tdata = M_TDATA_W'(data_bit);
  assign m_axis_tuser = undecided;

endmodule

`default_nettype wire

[design/ehbd_checker.sv]
// ehbd_checker: port-level checks of the echo hiding bit detector, bound
// to the top level; depends on ehbd_pkg
`timescale 1ns / 1ps
`default_nettype none

module ehbd_checker
  import ehbd_pkg::*;
(
  input wire logic                 clk_i,
  input wire logic                 rst_ni,
  input wire logic                 s_axis_tvalid,
  input wire logic                 s_axis_tready,
  input wire logic                 m_axis_tvalid,
  input wire logic                 m_axis_tready,
  input wire logic [M_TDATA_W-1:0] m_axis_tdata,
  input wire logic [0:0]           m_axis_tuser,
  input wire logic                 psel,
  input wire logic                 penable,
  input wire logic                 pwrite,
  input wire logic [PADDR_W-1:0]   paddr,
  input wire logic [PDATA_W-1:0]   pwdata,
  input wire logic [PDATA_W-1:0]   prdata,
  input wire logic                 pready
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result word changed while stalled");

  // every taken sample word is followed by a ring read cycle
  a_in_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken in the ring read cycle");

  // a result never appears right after a sample word is taken
  a_out_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> !$past(s_axis_tvalid && s_axis_tready))
    else $error("result word without segment end work");

  // a written short lag reads back on the next cycle
  a_reg_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (psel && penable && pwrite && pready && paddr[3:2] == REG_LAG_SHORT) ##1
      (psel && !pwrite && paddr[3:2] == REG_LAG_SHORT) |->
      prdata[LAG_W-1:0] == $past(pwdata[LAG_W-1:0]))
    else $error("short lag readback mismatch");

endmodule

bind echo_hiding_bit_detector ehbd_checker u_ehbd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .psel          (psel),
  .penable       (penable),
  .pwrite        (pwrite),
  .paddr         (paddr),
  .pwdata        (pwdata),
  .prdata        (prdata),
  .pready        (pready)
);

`default_nettype wire
